// ----- rtl/ecs_pkg.sv -----
// Shared types and constants for the emptiest channel selector.
// Standalone package: no dependencies.
`timescale 1ns / 1ps

package ecs_pkg;

  // Default table depths
  localparam int unsigned MEAS_DEPTH_DEF  = 32;
  localparam int unsigned ALLOW_DEPTH_DEF = 32;

  // Field widths
  localparam int unsigned CHAN_W = 16;
  localparam int unsigned UTIL_W = 10;

  // Utilisation is saturated to this value on load
  localparam logic [UTIL_W-1:0] UTIL_MAX = 10'd1000;

  // Guard window after reset
  localparam logic [CHAN_W-1:0] GUARD_RESET = 16'd20;

  // Request kinds
  localparam logic [1:0] KIND_MEAS   = 2'd0;
  localparam logic [1:0] KIND_ALLOW  = 2'd1;
  localparam logic [1:0] KIND_SELECT = 2'd2;

  // Register byte addresses
  localparam logic [2:0] ADDR_GUARD_WINDOW = 3'd0;

  // Candidate token travelling along the measurement cell row
  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] chan;
    logic [UTIL_W-1:0] guard;
    logic              own_seen;
    logic [UTIL_W-1:0] own;
  } ecs_tok_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } ecs_state_e;

endpackage

// ----- rtl/emptiest_channel_selector.sv -----
// Emptiest channel selector, top level. Loads (kinds 0 and 1) are accepted back to back.
// During a select request, allowlist entries leave the RAM one per cycle and each
// crosses the row of MEAS_DEPTH measurement cells, one cell per cycle. Inputs stall
// while a select runs, longer while an earlier result still waits to be taken.
// Reset (asynchronous, active low) empties both tables, clears the dropped flag and
// sets guard_window to 20; no clearing pass. Depends on ecs_pkg, ecs_ram, ecs_cell, ecs_pick.
`timescale 1ns / 1ps

module emptiest_channel_selector #(
  parameter int unsigned MEAS_DEPTH  = ecs_pkg::MEAS_DEPTH_DEF,
  parameter int unsigned ALLOW_DEPTH = ecs_pkg::ALLOW_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // channel[15:0], util[25:16],
                                       // except_channel[41:26], zero fill
  input  logic [1:0]  s_axis_tuser_i,  // kind[1:0]
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // best_channel[15:0], dropped[16], zero fill
  // Configuration port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned MCW = $clog2(MEAS_DEPTH + 1);
  localparam int unsigned ACW = $clog2(ALLOW_DEPTH + 1);
  localparam int unsigned AAW = (ALLOW_DEPTH > 1) ? $clog2(ALLOW_DEPTH) : 1;
  localparam int unsigned DW  = $clog2(MEAS_DEPTH + 4);
  localparam logic [DW-1:0] DRAIN_LEN = DW'(MEAS_DEPTH + 3);

  ecs_pkg::ecs_state_e        state_q, state_d;
  logic [ecs_pkg::CHAN_W-1:0] guard_window_q;
  logic [MCW-1:0]             meas_count_q;
  logic [ACW-1:0]             allow_count_q;
  logic                       dropped_q;
  logic [ACW-1:0]             rd_idx_q;
  logic [DW-1:0]              drain_q;
  logic                       issued_q;
  logic [ecs_pkg::CHAN_W-1:0] except_q;
  logic                       m_valid_q;
  logic [ecs_pkg::CHAN_W-1:0] best_q;
  logic                       drop_out_q;

  logic                       in_acc;
  logic [1:0]                 kind;
  logic [ecs_pkg::CHAN_W-1:0] in_chan;
  logic [ecs_pkg::UTIL_W-1:0] in_util;
  logic [ecs_pkg::UTIL_W-1:0] util_sat;
  logic [ecs_pkg::CHAN_W-1:0] in_except;
  logic                       meas_load, allow_load, meas_full, allow_full;
  logic                       start, scan_rd, drain_load, finish;
  logic                       cfg_wr;
  logic [ecs_pkg::CHAN_W-1:0] ram_rdata;
  logic [ecs_pkg::CHAN_W-1:0] best_chan;
  ecs_pkg::ecs_tok_t          tok [MEAS_DEPTH+1];

  // Unpack the request
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign kind      = s_axis_tuser_i;
  assign in_chan   = s_axis_tdata_i[15:0];
  assign in_util   = s_axis_tdata_i[25:16];
  assign in_except = s_axis_tdata_i[41:26];
  assign util_sat  = (in_util > ecs_pkg::UTIL_MAX) ? ecs_pkg::UTIL_MAX : in_util;

  assign s_axis_tready_o = (state_q == ecs_pkg::ST_IDLE);

  assign meas_full  = (meas_count_q == MCW'(MEAS_DEPTH));
  assign allow_full = (allow_count_q == ACW'(ALLOW_DEPTH));
  assign meas_load  = in_acc && (kind == ecs_pkg::KIND_MEAS) && !meas_full;
  assign allow_load = in_acc && (kind == ecs_pkg::KIND_ALLOW) && !allow_full;

  // Configuration register
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && (paddr_i == ecs_pkg::ADDR_GUARD_WINDOW);
  assign prdata_o = (paddr_i == ecs_pkg::ADDR_GUARD_WINDOW) ? {16'b0, guard_window_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      guard_window_q <= ecs_pkg::GUARD_RESET;
    end else if (cfg_wr) begin
      guard_window_q <= pwdata_i[15:0];
    end
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_d    = state_q;
    start      = 1'b0;
    scan_rd    = 1'b0;
    drain_load = 1'b0;
    finish     = 1'b0;
    case (state_q)
      ecs_pkg::ST_IDLE: begin
        if (in_acc && (kind == ecs_pkg::KIND_SELECT)) begin
          start   = 1'b1;
          state_d = ecs_pkg::ST_SCAN;
        end
      end
      ecs_pkg::ST_SCAN: begin
        if (rd_idx_q < allow_count_q) begin
          scan_rd = 1'b1;
        end else begin
          drain_load = 1'b1;
          state_d    = ecs_pkg::ST_DRAIN;
        end
      end
      ecs_pkg::ST_DRAIN: begin
        if (drain_q == '0) begin
          state_d = ecs_pkg::ST_FINISH;
        end
      end
      ecs_pkg::ST_FINISH: begin
        if (!m_valid_q || m_axis_tready_i) begin
          finish  = 1'b1;
          state_d = ecs_pkg::ST_IDLE;
        end
      end
      default: state_d = ecs_pkg::ST_IDLE;
    endcase
  end

  // Sequencer state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ecs_pkg::ST_IDLE;
      meas_count_q  <= '0;
      allow_count_q <= '0;
      dropped_q     <= 1'b0;
      rd_idx_q      <= '0;
      drain_q       <= '0;
      issued_q      <= 1'b0;
      m_valid_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= scan_rd;
      if (finish) begin
        meas_count_q  <= '0;
        allow_count_q <= '0;
        dropped_q     <= 1'b0;
      end else begin
        if (meas_load) begin
          meas_count_q <= meas_count_q + 1'b1;
        end
        if (allow_load) begin
          allow_count_q <= allow_count_q + 1'b1;
        end
        if (in_acc && (((kind == ecs_pkg::KIND_MEAS) && meas_full) ||
                       ((kind == ecs_pkg::KIND_ALLOW) && allow_full))) begin
          dropped_q <= 1'b1;
        end
      end
      if (start) begin
        rd_idx_q <= '0;
      end else if (scan_rd) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (drain_load) begin
        drain_q <= DRAIN_LEN;
      end else if ((state_q == ecs_pkg::ST_DRAIN) && (drain_q != '0)) begin
        drain_q <= drain_q - 1'b1;
      end
      if (finish) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Hold the excluded channel and the result
  always_ff @(posedge clk_i) begin
    if (start) begin
      except_q <= in_except;
    end
    if (finish) begin
      best_q     <= best_chan;
      drop_out_q <= dropped_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'b0, drop_out_q, best_q};

  // Allowlist store
  ecs_ram #(
    .WIDTH (ecs_pkg::CHAN_W),
    .DEPTH (ALLOW_DEPTH)
  ) u_allow_ram (
    .clk_i   (clk_i),
    .we_i    (allow_load),
    .waddr_i (allow_count_q[AAW-1:0]),
    .wdata_i (in_chan),
    .raddr_i (rd_idx_q[AAW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Inject candidates into the head of the cell row
  always_comb begin
    tok[0]          = '0;
    tok[0].valid    = issued_q && (ram_rdata != except_q);
    tok[0].chan     = ram_rdata;
  end

  // Row of measurement cells
  for (genvar i = 0; i < MEAS_DEPTH; i++) begin : g_cell
    localparam logic [MCW-1:0] IDX = MCW'(i);
    ecs_cell u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .we_i           (meas_load && (meas_count_q == IDX)),
      .wchan_i        (in_chan),
      .wutil_i        (util_sat),
      .active_i       (IDX < meas_count_q),
      .guard_window_i (guard_window_q),
      .tok_i          (tok[i]),
      .tok_o          (tok[i+1])
    );
  end

  // Keep the best candidate leaving the row
  ecs_pick u_pick (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (start),
    .tok_i       (tok[MEAS_DEPTH]),
    .best_chan_o (best_chan)
  );

endmodule

// ----- rtl/ecs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ecs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ecs_cell.sv -----
// One measurement cell: holds a stored measurement and folds it into the
// candidate token passing by. Depends on ecs_pkg.
`timescale 1ns / 1ps

module ecs_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [ecs_pkg::CHAN_W-1:0] wchan_i,
  input  logic [ecs_pkg::UTIL_W-1:0] wutil_i,
  input  logic                      active_i,
  input  logic [ecs_pkg::CHAN_W-1:0] guard_window_i,
  input  ecs_pkg::ecs_tok_t         tok_i,
  output ecs_pkg::ecs_tok_t         tok_o
);

  logic [ecs_pkg::CHAN_W-1:0] chan_q;
  logic [ecs_pkg::UTIL_W-1:0] util_q;
  logic [ecs_pkg::CHAN_W-1:0] chan_gap;
  logic                       hit;
  ecs_pkg::ecs_tok_t          tok_d;
  ecs_pkg::ecs_tok_t          tok_q;

  // Hold the measurement
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      chan_q <= wchan_i;
      util_q <= wutil_i;
    end
  end

  // Fold this measurement into the candidate when it lies in the window
  always_comb begin
    chan_gap = (chan_q >= tok_i.chan) ? (chan_q - tok_i.chan) : (tok_i.chan - chan_q);
    hit      = tok_i.valid && active_i && (chan_gap <= guard_window_i);
    tok_d    = tok_i;
    if (hit && (util_q > tok_i.guard)) begin
      tok_d.guard = util_q;
    end
    if (hit && (chan_q == tok_i.chan)) begin
      tok_d.own_seen = 1'b1;
      tok_d.own      = util_q;
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ----- rtl/ecs_pick.sv -----
// End-of-row comparator: keeps the best finished candidate so far.
// Depends on ecs_pkg.
`timescale 1ns / 1ps

module ecs_pick (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  ecs_pkg::ecs_tok_t          tok_i,
  output logic [ecs_pkg::CHAN_W-1:0] best_chan_o
);

  logic                       have_q;
  logic [ecs_pkg::UTIL_W-1:0] best_guard_q;
  logic [ecs_pkg::UTIL_W-1:0] win_own_q;
  logic [ecs_pkg::CHAN_W-1:0] best_chan_q;
  logic                       take;

  // Strictly better only, so earlier allowlist entries win ties
  assign take = tok_i.valid && tok_i.own_seen &&
                (!have_q || (tok_i.guard < best_guard_q) ||
                 ((tok_i.guard == best_guard_q) && (tok_i.own < win_own_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (clear_i) begin
      have_q <= 1'b0;
    end else if (take) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      best_chan_q <= '0;
    end else if (take) begin
      best_guard_q <= tok_i.guard;
      win_own_q    <= tok_i.own;
      best_chan_q  <= tok_i.chan;
    end
  end

  assign best_chan_o = best_chan_q;

endmodule

// ----- bench/emptiest_channel_selector_tb.sv -----
// Self-checking bench for emptiest_channel_selector: load/select requests on the input
// stream, picks checked on the result stream against an in-bench predictor.
// Depends on ecs_pkg and the emptiest_channel_selector RTL.
`timescale 1ns / 1ps

module emptiest_channel_selector_tb;
  import ecs_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned SETTLE_CYCLES = 80;

  typedef struct packed {
    logic [1:0]        kind;
    logic [CHAN_W-1:0] chan;
    logic [UTIL_W-1:0] util;
    logic [CHAN_W-1:0] excl;
  } ecs_req_t;

  typedef struct packed {
    logic [CHAN_W-1:0] best;
    logic              dropped;
  } ecs_pick_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        psel_i = 1'b0;
  logic        penable_i = 1'b0;
  logic        pwrite_i = 1'b0;
  logic [2:0]  paddr_i = '0;
  logic [31:0] pwdata_i = '0;
  logic [31:0] prdata_o;
  logic        pready_o;

  emptiest_channel_selector uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel_i          (psel_i),
    .penable_i       (penable_i),
    .pwrite_i        (pwrite_i),
    .paddr_i         (paddr_i),
    .pwdata_i        (pwdata_i),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  // Predictor state
  logic [CHAN_W-1:0] meas_chan [MEAS_DEPTH_DEF];
  logic [UTIL_W-1:0] meas_util [MEAS_DEPTH_DEF];
  int unsigned       meas_cnt = 0;
  logic [CHAN_W-1:0] allow_chan [ALLOW_DEPTH_DEF];
  int unsigned       allow_cnt = 0;
  bit                drop_flag = 1'b0;
  logic [CHAN_W-1:0] guard_cfg = GUARD_RESET;

  ecs_req_t  pending_reqs [$];
  ecs_pick_t picks_due [$];
  ecs_req_t  next_req;
  bit        req_taken = 1'b0;
  bit        calm = 1'b0;
  int unsigned n_queued = 0, n_accepted = 0, n_picks = 0, n_drop_picks = 0;
  int unsigned n_guard_settings = 1, mismatches = 0, cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d picks outstanding", cycles, picks_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Pick the allowlisted channel with the quietest neighbourhood
  function automatic logic [CHAN_W-1:0] emptiest_allowed(input logic [CHAN_W-1:0] excl);
    logic [CHAN_W-1:0] best_ch, ch, mc;
    int unsigned best_nb, win_own, nb, own, gap;
    bit have, seen;
    best_ch = '0;
    best_nb = 0;
    win_own = 0;
    have = 1'b0;
    for (int a = 0; a < allow_cnt; a++) begin
      ch = allow_chan[a];
      if (ch == excl) continue;
      nb = 0;
      own = 0;
      seen = 1'b0;
      for (int m = 0; m < meas_cnt; m++) begin
        mc = meas_chan[m];
        gap = (mc >= ch) ? int'(mc) - int'(ch) : int'(ch) - int'(mc);
        if (gap > 32'(guard_cfg)) continue;
        if (32'(meas_util[m]) > nb) nb = 32'(meas_util[m]);
        if (mc == ch) begin
          seen = 1'b1;
          own = 32'(meas_util[m]);
        end
      end
      if (!seen) continue;
      if (!have || nb < best_nb || (nb == best_nb && own < win_own)) begin
        have = 1'b1;
        best_nb = nb;
        win_own = own;
        best_ch = ch;
      end
    end
    return best_ch;
  endfunction

  // Advance the predictor by one accepted request
  task automatic model_request(input ecs_req_t r);
    ecs_pick_t p;
    case (r.kind)
      KIND_MEAS: begin
        if (meas_cnt < MEAS_DEPTH_DEF) begin
          meas_chan[meas_cnt] = r.chan;
          meas_util[meas_cnt] = (r.util > UTIL_MAX) ? UTIL_MAX : r.util;
          meas_cnt++;
        end else begin
          drop_flag = 1'b1;
        end
      end
      KIND_ALLOW: begin
        if (allow_cnt < ALLOW_DEPTH_DEF) begin
          allow_chan[allow_cnt] = r.chan;
          allow_cnt++;
        end else begin
          drop_flag = 1'b1;
        end
      end
      KIND_SELECT: begin
        p.best = emptiest_allowed(r.excl);
        p.dropped = drop_flag;
        picks_due.push_back(p);
        meas_cnt = 0;
        allow_cnt = 0;
        drop_flag = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  // Request driver: present the next queued request, idling at random
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || req_taken) begin
      if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
        next_req = pending_reqs.pop_front();
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= {6'b0, next_req.excl, next_req.util, next_req.chan};
        s_axis_tuser_i  <= next_req.kind;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Result receiver: stall at random
  always @(negedge clk_i) begin
    m_axis_tready_i <= rst_ni && (calm || $urandom_range(0, 99) >= 29);
  end

  // Monitor: feed accepted requests to the predictor and check each pick
  always @(posedge clk_i) begin
    ecs_req_t  r;
    ecs_pick_t want;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        r.kind = s_axis_tuser_i;
        r.chan = s_axis_tdata_i[15:0];
        r.util = s_axis_tdata_i[25:16];
        r.excl = s_axis_tdata_i[41:26];
        model_request(r);
        n_accepted++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (picks_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected pick best=%0d dropped=%0b", $realtime,
                     m_axis_tdata_o[15:0], m_axis_tdata_o[16]);
        end else begin
          want = picks_due.pop_front();
          n_picks++;
          if (want.dropped) n_drop_picks++;
          if (m_axis_tdata_o[15:0] !== want.best || m_axis_tdata_o[16] !== want.dropped) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: pick %0d: expected best=%0d dropped=%0b, got best=%0d dropped=%0b",
                       $realtime, n_picks, want.best, want.dropped,
                       m_axis_tdata_o[15:0], m_axis_tdata_o[16]);
          end
        end
      end
    end
  end

  task automatic push_req(input logic [1:0] kind, input logic [CHAN_W-1:0] chan,
                          input logic [UTIL_W-1:0] util, input logic [CHAN_W-1:0] excl);
    ecs_req_t r;
    r.kind = kind;
    r.chan = chan;
    r.util = util;
    r.excl = excl;
    pending_reqs.push_back(r);
    n_queued++;
  endtask

  // Wait for every request and pick, then let any select still walking finish
  task automatic settle();
    wait (n_accepted == n_queued);
    wait (picks_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_guard(input logic [CHAN_W-1:0] val);
    @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= ADDR_GUARD_WINDOW;
    pwdata_i  <= {16'b0, val};
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    guard_cfg = val;
    n_guard_settings++;
  endtask

  // One scan: measurements and allowlist entries, clustered unless spread is zero, then a select
  task automatic queue_scan(output int unsigned n_items);
    int unsigned n_meas, n_allow, spread, r;
    logic [CHAN_W-1:0] base, ch, ex;
    logic [UTIL_W-1:0] u;
    logic [CHAN_W-1:0] measured [$];
    logic [CHAN_W-1:0] allowed [$];
    n_meas  = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 10);
    n_allow = ($urandom_range(0, 14) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 10);
    spread  = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 80);
    base    = CHAN_W'($urandom_range(0, 65535));
    n_items = 0;
    while (n_meas + n_allow != 0) begin
      // Occasional unused-kind noise
      if ($urandom_range(0, 24) == 0) begin
        push_req(KIND_UNUSED, CHAN_W'($urandom_range(0, 65535)),
                 UTIL_W'($urandom_range(0, 1023)), CHAN_W'($urandom_range(0, 65535)));
      end
      ch = (spread == 0) ? CHAN_W'($urandom_range(0, 65535))
                         : CHAN_W'(base + $urandom_range(0, spread));
      if (n_meas != 0 && (n_allow == 0 || $urandom_range(0, 1) == 0)) begin
        r = $urandom_range(0, 9);
        if (r == 0) u = UTIL_W'($urandom_range(1001, 1023));
        else if (r < 4) u = UTIL_W'($urandom_range(0, 8) * 125);
        else u = UTIL_W'($urandom_range(0, 1000));
        measured.push_back(ch);
        push_req(KIND_MEAS, ch, u, CHAN_W'($urandom_range(0, 65535)));
        n_meas--;
      end else begin
        if (measured.size() != 0 && $urandom_range(0, 3) != 0)
          ch = measured[$urandom_range(0, measured.size() - 1)];
        allowed.push_back(ch);
        push_req(KIND_ALLOW, ch, UTIL_W'($urandom_range(0, 1023)),
                 CHAN_W'($urandom_range(0, 65535)));
        n_allow--;
      end
      n_items++;
    end
    ex = (allowed.size() != 0 && $urandom_range(0, 2) == 0)
         ? allowed[$urandom_range(0, allowed.size() - 1)]
         : CHAN_W'($urandom_range(0, 65535));
    push_req(KIND_SELECT, CHAN_W'($urandom_range(0, 65535)),
             UTIL_W'($urandom_range(0, 1023)), ex);
    n_items++;
  endtask

  initial begin
    logic [CHAN_W-1:0] guard_plan [8];
    int unsigned phase_items, scan_items;
    guard_plan = '{16'd0, 16'd65535, 16'd20, 16'd1, CHAN_W'($urandom_range(2, 200)),
                   16'd5, CHAN_W'($urandom_range(0, 65535)), 16'd40};

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty select, unused kind, saturation, unmeasured and excluded channels
    push_req(KIND_SELECT, 16'd0, 10'd0, 16'd0);
    push_req(KIND_UNUSED, 16'hFFFF, 10'h3FF, 16'hFFFF);
    push_req(KIND_MEAS, 16'd100, 10'd1023, 16'd0);
    push_req(KIND_MEAS, 16'd200, 10'd300, 16'd0);
    push_req(KIND_MEAS, 16'd65535, 10'd5, 16'd0);
    push_req(KIND_ALLOW, 16'd100, 10'd0, 16'd0);
    push_req(KIND_ALLOW, 16'd200, 10'd0, 16'd0);
    push_req(KIND_ALLOW, 16'd300, 10'd0, 16'd0);
    push_req(KIND_ALLOW, 16'd65535, 10'd0, 16'd0);
    push_req(KIND_SELECT, 16'd0, 10'd0, 16'd65535);
    // Equal neighbourhoods, decided by own utilisation
    push_req(KIND_MEAS, 16'd1000, 10'd500, 16'd0);
    push_req(KIND_MEAS, 16'd2000, 10'd500, 16'd0);
    push_req(KIND_MEAS, 16'd2000, 10'd400, 16'd0);
    push_req(KIND_MEAS, 16'd3000, 10'd500, 16'd0);
    push_req(KIND_ALLOW, 16'd3000, 10'd0, 16'd0);
    push_req(KIND_ALLOW, 16'd1000, 10'd0, 16'd0);
    push_req(KIND_ALLOW, 16'd2000, 10'd0, 16'd0);
    push_req(KIND_SELECT, 16'd0, 10'd0, 16'd7);
    // Full tie goes to the earliest entry, which is channel zero
    push_req(KIND_MEAS, 16'd0, 10'd0, 16'd0);
    push_req(KIND_MEAS, 16'd40, 10'd0, 16'd0);
    push_req(KIND_ALLOW, 16'd0, 10'd0, 16'd0);
    push_req(KIND_ALLOW, 16'd40, 10'd0, 16'd0);
    push_req(KIND_SELECT, 16'd0, 10'd0, 16'd1);
    settle();

    // Random scans under each guard window, one phase without idling
    for (int ph = 0; ph < 8; ph++) begin
      write_guard(guard_plan[ph]);
      calm = (ph == 2);
      phase_items = 0;
      while (phase_items < 225) begin
        queue_scan(scan_items);
        phase_items += scan_items;
      end
      settle();
    end
    calm = 1'b0;

    $display("%0d requests sent, %0d picks checked (%0d flagging dropped loads)",
             n_queued, n_picks, n_drop_picks);
    $display("%0d guard window settings exercised, %0d mismatches", n_guard_settings,
             mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
